/* design/mste_pkg.sv */
// Package for the multitouch slot event tracker: field widths, event codes,
// register indexes, queue entry and back-end state types. No dependencies.
package mste_pkg;

  localparam int unsigned SlotCountDef = 10;
  localparam int unsigned SlotMax      = 10;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned IdW   = 17;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AxW   = 16;

  localparam logic [5:0] CodeSlot     = 6'h2F;
  localparam logic [5:0] CodeMajor    = 6'h30;
  localparam logic [5:0] CodeX        = 6'h35;
  localparam logic [5:0] CodeY        = 6'h36;
  localparam logic [5:0] CodeId       = 6'h39;
  localparam logic [5:0] CodePressure = 6'h3A;
  localparam logic [5:0] CodeNone     = 6'h00;

  localparam logic [2:0] RegPalm = 3'd0;
  localparam logic [2:0] RegXx   = 3'd1;
  localparam logic [2:0] RegXy   = 3'd2;
  localparam logic [2:0] RegXoff = 3'd3;
  localparam logic [2:0] RegYx   = 3'd4;
  localparam logic [2:0] RegYy   = 3'd5;
  localparam logic [2:0] RegYoff = 3'd6;

  localparam logic [15:0] PalmReset = 16'd200;
  localparam logic signed [31:0] CalOne = 32'sd65536;

  // Accepted report or sync, as passed from front to back
  typedef struct packed {
    logic            sync;
    logic [3:0]      slot;
    logic [IdW-1:0]  id;
    logic [15:0]     raw_x;
    logic [15:0]     raw_y;
    logic [15:0]     pressure;
    logic [15:0]     major;
    logic [15:0]     minor;
  } cmd_t;

  typedef enum logic [3:0] {
    StIdle, StMulA, StMulB, StSum, StWrite,
    StSlot, StEmit, StNext, StSync
  } back_state_e;

  typedef enum logic [2:0] {
    EvSlot, EvId, EvX, EvY, EvPressure, EvMajor
  } ev_e;

  // Saturate a floor-shifted 50-bit sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
    logic signed [33:0] q;
    q = s[49:16];
    if (q > 34'sh0_7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (q < -34'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else                            sat32 = q[31:0];
  endfunction

endpackage

/* design/multitouch_slot_event_tracker.sv */
// Top level of the multitouch slot event tracker: config registers, front
// end, queue, back end. Depends on mste_pkg, mste_front, mste_back.
//
// channel   dir  beat content
// s_axis    in   report or sync (tuser = operation)
// m_axis    out  one event; tlast on the sync event
// cfg       in   register index and write data
//
// The back end takes an item from the queue in its idle state. A report then
// takes two multiply steps and a sum per axis, then the slot write, and no new
// item is taken before it ends. A sync walks every slot: a check step per slot,
// an emit step per event and a step to the next slot, then the sync event. A 2-entry
// queue lets reports enter while the back end works; the output register holds
// a stalled event. Reset restores all slots at once, no clearing pass.
module multitouch_slot_event_tracker #(
  parameter int unsigned SlotCount = mste_pkg::SlotCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: slot_index[3:0], contact_id[20:4], raw_x[36:21], raw_y[52:37],
  // contact_pressure[68:53], axis_major[84:69], axis_minor[100:85], zeros
  input  logic [103:0] s_axis_tdata,
  // tuser: operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: event_code[5:0], event_value[37:6], touching_count[41:38], zeros
  output logic [47:0] m_axis_tdata,
  // tuser: event_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import mste_pkg::*;

  logic [15:0]        palm_q;
  logic signed [31:0] cal_q [6];
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [5:0] code;
  logic signed [31:0] val;
  logic [3:0] cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palm_q <= PalmReset;
      cal_q[0] <= CalOne; cal_q[1] <= '0; cal_q[2] <= '0;
      cal_q[3] <= '0; cal_q[4] <= CalOne; cal_q[5] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPalm: palm_q <= cfg_data_i[15:0];
        RegXx:   cal_q[0] <= cfg_data_i;
        RegXy:   cal_q[1] <= cfg_data_i;
        RegXoff: cal_q[2] <= cfg_data_i;
        RegYx:   cal_q[3] <= cfg_data_i;
        RegYy:   cal_q[4] <= cfg_data_i;
        RegYoff: cal_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_cmd.sync     = s_axis_tuser;
  assign in_cmd.slot     = s_axis_tdata[3:0];
  assign in_cmd.id       = s_axis_tdata[20:4];
  assign in_cmd.raw_x    = s_axis_tdata[36:21];
  assign in_cmd.raw_y    = s_axis_tdata[52:37];
  assign in_cmd.pressure = s_axis_tdata[68:53];
  assign in_cmd.major    = s_axis_tdata[84:69];
  assign in_cmd.minor    = s_axis_tdata[100:85];

  mste_front #(.SlotCount(SlotCount)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .palm_limit_i(palm_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  mste_back #(.SlotCount(SlotCount)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .cal_i(cal_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_code_o(code), .out_value_o(val),
    .out_count_o(cnt), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, cnt, val, code};

  a_last_is_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser)) else $error("tlast without sync");
  a_sync_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == CodeNone))
    else $error("sync event with axis code");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (32'(m_axis_tdata[41:38]) <= SlotCount))
    else $error("active count above slot count");
endmodule

/* design/mste_front.sv */
// Front end: accepts input beats, drops out-of-range and palm reports,
// and pushes the rest into a short queue. Depends on mste_pkg.
module mste_front #(
  parameter int unsigned SlotCount = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mste_pkg::cmd_t      in_cmd_i,
  input  logic [15:0]         palm_limit_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output mste_pkg::cmd_t      q_cmd_o
);
  import mste_pkg::*;

  cmd_t        mem_q [QueueDepth];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        keep, push, pop;

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign keep = in_cmd_i.sync ||
                ((32'(in_cmd_i.slot) < SlotCount) &&
                 !((palm_limit_i != '0) && (in_cmd_i.major > palm_limit_i)));
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end
endmodule

/* design/mste_back.sv */
// Back end: calibrates reports into the slot table and walks the slots on
// sync, driving one event per beat into an output register. Depends on mste_pkg.
module mste_back #(
  parameter int unsigned SlotCount = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_ready_o,
  input  mste_pkg::cmd_t           q_cmd_i,
  input  logic signed [31:0]       cal_i [6],
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_kind_o,
  output logic [5:0]               out_code_o,
  output logic signed [31:0]       out_value_o,
  output logic [3:0]               out_count_o,
  output logic                     out_last_o
);
  import mste_pkg::*;

  localparam int unsigned SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  back_state_e st_q, st_d;
  cmd_t        cmd_q;

  logic [IdW-1:0]     now_id_q   [SlotCount];
  logic [31:0]        now_x_q    [SlotCount];
  logic [31:0]        now_y_q    [SlotCount];
  logic [15:0]        now_p_q    [SlotCount];
  logic [15:0]        now_maj_q  [SlotCount];
  logic [15:0]        now_min_q  [SlotCount];
  logic [SlotCount-1:0] now_act_q, past_act_q;
  logic [31:0]        past_x_q   [SlotCount];
  logic [31:0]        past_y_q   [SlotCount];
  logic [15:0]        past_p_q   [SlotCount];

  logic signed [48:0] pa_q, pb_q;
  logic signed [49:0] sx_q, sy_q;
  logic               axis_q;
  logic signed [31:0] cx_q;

  logic [SlotW-1:0] idx_q;
  ev_e              ev_q;
  logic [3:0]       tot_q;

  logic        ov_q;
  logic        okind_q, olast_q;
  logic [5:0]  ocode_q;
  logic [31:0] oval_q;
  logic [3:0]  ocnt_q;

  logic was, is, mv, pch, can_out, do_out;
  logic [5:0]  e_code;
  logic [31:0] e_val;
  logic        e_end;

  assign q_ready_o = (st_q == StIdle);
  assign can_out = !ov_q || out_ready_i;

  assign was = past_act_q[idx_q];
  assign is  = now_act_q[idx_q];
  assign mv  = (now_x_q[idx_q] != past_x_q[idx_q]) || (now_y_q[idx_q] != past_y_q[idx_q]);
  assign pch = now_p_q[idx_q] != past_p_q[idx_q];

  // Event of current step; e_end marks the slot's final event
  always_comb begin
    e_code = CodeSlot;
    e_val  = 32'(idx_q);
    e_end  = 1'b0;
    case (ev_q)
      EvSlot: begin
        e_code = CodeSlot; e_val = 32'(idx_q);
      end
      EvId: begin
        e_code = CodeId;
        e_val  = is ? {{15{now_id_q[idx_q][IdW-1]}}, now_id_q[idx_q]} : 32'hFFFF_FFFF;
        e_end  = !is;
      end
      EvX: begin
        e_code = CodeX; e_val = now_x_q[idx_q];
      end
      EvY: begin
        e_code = CodeY; e_val = now_y_q[idx_q];
        e_end  = was && !pch;
      end
      EvPressure: begin
        e_code = CodePressure; e_val = 32'(now_p_q[idx_q]);
        e_end  = was;
      end
      EvMajor: begin
        e_code = CodeMajor; e_val = 32'(now_maj_q[idx_q]); e_end = 1'b1;
      end
      default: ;
    endcase
  end

  assign do_out = ((st_q == StEmit) || (st_q == StSync)) && can_out;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (q_valid_i) st_d = q_cmd_i.sync ? StSlot : StMulA;
      StMulA:  st_d = StMulB;
      StMulB:  st_d = StSum;
      StSum:   st_d = axis_q ? StWrite : StMulA;
      StWrite: st_d = StIdle;
      StSlot:  st_d = ((!was && is) || (was && !is) || (was && is && mv)) ? StEmit : StNext;
      StEmit:  if (can_out && e_end) st_d = StNext;
      StNext:  st_d = (32'(idx_q) == SlotCount - 1) ? StSync : StSlot;
      StSync:  if (can_out) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
      now_act_q <= '0;
      past_act_q <= '0;
      tot_q <= '0;
      idx_q <= '0;
      ev_q <= EvSlot;
      axis_q <= 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
        now_id_q[i] <= '1;
        now_x_q[i] <= '0; now_y_q[i] <= '0; now_p_q[i] <= '0;
        now_maj_q[i] <= '0; now_min_q[i] <= '0;
        past_x_q[i] <= '0; past_y_q[i] <= '0; past_p_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (out_ready_i) ov_q <= 1'b0;
      if (do_out) ov_q <= 1'b1;
      case (st_q)
        StIdle: if (q_valid_i) begin
          idx_q <= '0; tot_q <= '0; axis_q <= 1'b0;
        end
        StSum: axis_q <= 1'b1;
        StWrite: begin
          now_id_q[cmd_q.slot[SlotW-1:0]]  <= cmd_q.id;
          now_x_q[cmd_q.slot[SlotW-1:0]]   <= cx_q;
          now_y_q[cmd_q.slot[SlotW-1:0]]   <= sat32(sy_q);
          now_p_q[cmd_q.slot[SlotW-1:0]]   <= cmd_q.pressure;
          now_maj_q[cmd_q.slot[SlotW-1:0]] <= cmd_q.major;
          now_min_q[cmd_q.slot[SlotW-1:0]] <= cmd_q.minor;
          now_act_q[cmd_q.slot[SlotW-1:0]] <= !cmd_q.id[IdW-1];
        end
        StSlot: begin
          ev_q <= EvSlot;
          if (is) tot_q <= tot_q + 4'd1;
        end
        StEmit: if (can_out) begin
          case (ev_q)
            EvSlot:     ev_q <= was ? (is ? EvX : EvId) : EvId;
            EvId:       ev_q <= EvX;
            EvX:        ev_q <= EvY;
            EvY:        ev_q <= EvPressure;
            EvPressure: ev_q <= EvMajor;
            default:    ev_q <= EvSlot;
          endcase
        end
        StNext: begin
          past_x_q[idx_q] <= now_x_q[idx_q];
          past_y_q[idx_q] <= now_y_q[idx_q];
          past_p_q[idx_q] <= now_p_q[idx_q];
          past_act_q[idx_q] <= is;
          if (32'(idx_q) != SlotCount - 1) idx_q <= idx_q + SlotW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload: calibration datapath and output register
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) cmd_q <= q_cmd_i;
    case (st_q)
      StMulA: pa_q <= (axis_q ? cal_i[3] : cal_i[0]) * $signed({1'b0, cmd_q.raw_x});
      StMulB: pb_q <= (axis_q ? cal_i[4] : cal_i[1]) * $signed({1'b0, cmd_q.raw_y});
      StSum: begin
        if (axis_q) sy_q <= 50'(pa_q) + 50'(pb_q) + 50'(axis_q ? cal_i[5] : cal_i[2]);
        else begin
          sx_q <= 50'(pa_q) + 50'(pb_q) + 50'(cal_i[2]);
        end
      end
      default: ;
    endcase
    if (st_q == StMulA && axis_q) cx_q <= sat32(sx_q);
    if (do_out) begin
      okind_q <= (st_q == StSync);
      ocode_q <= (st_q == StSync) ? CodeNone : e_code;
      oval_q  <= (st_q == StSync) ? '0 : e_val;
      ocnt_q  <= (st_q == StSync) ? tot_q : '0;
      olast_q <= (st_q == StSync);
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_code_o  = ocode_q;
  assign out_value_o = oval_q;
  assign out_count_o = ocnt_q;
  assign out_last_o  = olast_q;
endmodule

/* test/multitouch_slot_event_tracker_test.sv */
// Testbench for multitouch_slot_event_tracker: random and directed reports and syncs
// are checked against a slot-tracking predictor, under several calibration settings.
// Depends on mste_pkg and the tracker RTL.
module multitouch_slot_event_tracker_test;
  import mste_pkg::*;

  localparam int Slots = int'(SlotCountDef);
  localparam int QuietLimit = 20000;

  typedef struct {
    bit               sync;
    bit [3:0]         slot;
    bit signed [16:0] id;
    bit [15:0]        x, y, pressure, major, minor;
  } touch_t;

  typedef struct {
    bit              kind;
    bit [5:0]        code;
    bit signed [31:0] value;
    bit [3:0]        count;
    bit              last;
  } touch_ev_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  multitouch_slot_event_tracker dut (.*);

  always #6 clk_i = ~clk_i;

  touch_t pending_q[$];
  touch_ev_t event_q[$];
  int errors = 0;
  int idle_pct = 38;
  int quiet = 0;
  bit in_acc = 1'b0;

  // predictor state
  bit [15:0] palm;
  int cxx, cxy, cxo, cyx, cyy, cyo;
  int signed now_id[Slots];
  int now_x[Slots], now_y[Slots], past_x[Slots], past_y[Slots];
  bit [15:0] now_p[Slots], now_maj[Slots], past_p[Slots];
  bit now_on[Slots], past_on[Slots];

  function automatic int calibrate(int c1, int c2, int off, bit [15:0] x, bit [15:0] y);
    longint s;
    s = longint'(c1) * longint'(x) + longint'(c2) * longint'(y) + longint'(off);
    s = s >>> 16;
    if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(s);
  endfunction

  function automatic void push_event(bit [5:0] code, int value);
    touch_ev_t e;
    e.kind = 1'b0; e.code = code; e.value = value; e.count = '0; e.last = 1'b0;
    event_q.push_back(e);
  endfunction

  function automatic void track_touch(touch_t t);
    touch_ev_t e;
    int n;
    n = 0;
    if (!t.sync) begin
      if (t.slot >= Slots) return;
      if (palm != 0 && t.major > palm) return;
      now_id[t.slot] = int'(t.id);
      now_x[t.slot] = calibrate(cxx, cxy, cxo, t.x, t.y);
      now_y[t.slot] = calibrate(cyx, cyy, cyo, t.x, t.y);
      now_p[t.slot] = t.pressure;
      now_maj[t.slot] = t.major;
      now_on[t.slot] = (t.id >= 0);
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (now_on[i]) n++;
      if (!past_on[i] && now_on[i]) begin
        push_event(CodeSlot, i);
        push_event(CodeId, now_id[i]);
        push_event(CodeX, now_x[i]);
        push_event(CodeY, now_y[i]);
        push_event(CodePressure, int'(now_p[i]));
        push_event(CodeMajor, int'(now_maj[i]));
      end else if (past_on[i] && !now_on[i]) begin
        push_event(CodeSlot, i);
        push_event(CodeId, -1);
      end else if (now_on[i] && (now_x[i] != past_x[i] || now_y[i] != past_y[i])) begin
        push_event(CodeSlot, i);
        push_event(CodeX, now_x[i]);
        push_event(CodeY, now_y[i]);
        if (now_p[i] != past_p[i]) push_event(CodePressure, int'(now_p[i]));
      end
      past_x[i] = now_x[i];
      past_y[i] = now_y[i];
      past_p[i] = now_p[i];
      past_on[i] = now_on[i];
    end
    e.kind = 1'b1; e.code = CodeNone; e.value = 0; e.count = 4'(n); e.last = 1'b1;
    event_q.push_back(e);
  endfunction

  // input driver
  touch_t cur;
  always @(negedge clk_i) begin
    bit nv;
    nv = s_axis_tvalid;
    if (rst_ni && (!s_axis_tvalid || in_acc)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = pending_q.pop_front();
        s_axis_tdata <= {3'b0, cur.minor, cur.major, cur.pressure, cur.y, cur.x,
                         cur.id, cur.slot};
        s_axis_tuser <= cur.sync;
        nv = 1'b1;
      end else begin
        nv = 1'b0;
      end
    end
    s_axis_tvalid <= nv;
    m_axis_tready <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    touch_ev_t e;
    bit act;
    in_acc = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      act = in_acc || (cfg_valid_i && cfg_ready_o) || (m_axis_tvalid && m_axis_tready);
      quiet <= act ? 0 : quiet + 1;
      if (in_acc) track_touch(cur);
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_q.size() == 0) begin
          errors++;
          $display("%0t unexpected event: got %h kind %b last %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          e = event_q.pop_front();
          if (m_axis_tuser !== e.kind || m_axis_tdata[5:0] !== e.code ||
              m_axis_tdata[37:6] !== e.value || m_axis_tdata[41:38] !== e.count ||
              m_axis_tdata[47:42] !== 6'b0 || m_axis_tlast !== e.last) begin
            errors++;
            $display("%0t event mismatch: expected kind %b code %h value %h count %0d last %b",
                     $time, e.kind, e.code, e.value, e.count, e.last);
            $display("%0t                 got kind %b code %h value %h count %0d last %b",
                     $time, m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6],
                     m_axis_tdata[41:38], m_axis_tlast);
          end
        end
      end
      if (quiet >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegPalm: palm = val[15:0];
      RegXx:   cxx = val;
      RegXy:   cxy = val;
      RegXoff: cxo = val;
      RegYx:   cyx = val;
      RegYy:   cyy = val;
      RegYoff: cyo = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || event_q.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic void add_report(int slot, int id, int x, int y, int p, int maj, int mnr);
    touch_t t;
    t.sync = 1'b0; t.slot = 4'(slot); t.id = 17'(id); t.x = 16'(x); t.y = 16'(y);
    t.pressure = 16'(p); t.major = 16'(maj); t.minor = 16'(mnr);
    pending_q.push_back(t);
  endfunction

  function automatic void add_sync(bit junk);
    touch_t t;
    t.sync = 1'b1;
    t.slot = junk ? 4'($urandom) : '0; t.id = junk ? 17'($urandom) : '0;
    t.x = junk ? 16'($urandom) : '0; t.y = junk ? 16'($urandom) : '0;
    t.pressure = junk ? 16'($urandom) : '0; t.major = junk ? 16'($urandom) : '0;
    t.minor = junk ? 16'($urandom) : '0;
    pending_q.push_back(t);
  endfunction

  // well-formed frames with random content, a little noise
  function automatic void add_frames(int items);
    int k, slot, id;
    k = 0;
    while (k < items) begin
      for (int j = $urandom_range(1, 6); j > 0; j--) begin
        slot = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(Slots - 1);
        id = ($urandom_range(4) == 0) ? -1 : $urandom_range(65535);
        if ($urandom_range(2) == 0)
          add_report(slot, id, $urandom_range(3), $urandom_range(3), $urandom_range(1),
                     $urandom_range(255), $urandom);
        else
          add_report(slot, id, $urandom, $urandom, $urandom,
                     ($urandom_range(5) == 0) ? $urandom : $urandom_range(250), $urandom);
        k++;
      end
      add_sync($urandom_range(3) == 0);
      k++;
    end
  endfunction

  initial begin
    palm = PalmReset; cxx = CalOne; cxy = 0; cxo = 0; cyx = 0; cyy = CalOne; cyo = 0;
    for (int i = 0; i < Slots; i++) begin
      now_id[i] = -1; now_x[i] = 0; now_y[i] = 0; now_p[i] = 0; now_maj[i] = 0;
      now_on[i] = 0; past_x[i] = 0; past_y[i] = 0; past_p[i] = 0; past_on[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: down, palm edge, out-of-range slots, up, move with and without pressure
    add_report(0, 0, 0, 0, 0, 0, 0);
    add_report(9, 65535, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200, 16'hFFFF);
    add_report(1, 5, 100, 100, 10, 201, 0);
    add_report(10, 7, 1, 1, 1, 1, 1);
    add_report(15, 7, 1, 1, 1, 1, 1);
    add_sync(1'b0);
    add_sync(1'b1);
    add_report(0, -1, 5, 5, 5, 5, 5);
    add_report(9, 65535, 16'h1234, 16'hFFFF, 16'hFFFF, 3, 0);
    add_report(2, 3, 50, 60, 70, 80, 90);
    add_sync(1'b0);
    add_report(9, 65535, 16'h1234, 16'h0001, 16'h0002, 3, 0);
    add_report(2, 3, 50, 60, 71, 80, 90);
    add_sync(1'b1);
    drain();

    // extreme coefficients drive both saturation limits; palm rejection off
    write_reg(RegPalm, 32'd0);
    write_reg(RegXx, 32'h7FFF_FFFF);
    write_reg(RegXy, 32'h7FFF_FFFF);
    write_reg(RegXoff, 32'h7FFF_FFFF);
    write_reg(RegYx, 32'h8000_0000);
    write_reg(RegYy, 32'h8000_0000);
    write_reg(RegYoff, 32'h8000_0000);
    add_report(3, 1, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 0);
    add_report(4, 2, 0, 0, 1, 16'hFFFF, 0);
    add_sync(1'b0);
    add_frames(130);
    drain();

    write_reg(RegPalm, 32'd65535);
    write_reg(RegXx, $urandom);
    write_reg(RegXy, $urandom);
    write_reg(RegXoff, $urandom);
    write_reg(RegYx, $urandom_range(200000));
    write_reg(RegYy, -$urandom_range(200000));
    write_reg(RegYoff, $urandom);
    add_frames(130);
    drain();

    // no idling on either side
    idle_pct = 0;
    write_reg(RegPalm, 32'd200);
    write_reg(RegXx, CalOne);
    write_reg(RegYy, 32'd32768);
    write_reg(RegXoff, 32'hFFFF_0000);
    add_frames(130);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
